// ----- design/pbbn_pkg.sv -----
// Package for the printer back-channel byte normaliser.
// Holds the character codes and the state and result structs that the
// decoder and the top level share. It depends on nothing else.
package pbbn_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CTRL_A = 8'h01;
    localparam logic [7:0] CH_CTRL_D = 8'h04;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] TBCP_XOR  = 8'h40;

    // Flags carried from one byte to the next.
    typedef struct packed {
        logic prev_cr;
        logic tbcp;
        logic esc;
    } pbbn_state_t;

    // What one byte produces: at most one output word.
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       eoj;
    } pbbn_result_t;

endpackage

// ----- design/printer_backchannel_byte_normalizer.sv -----
// Top level of the printer back-channel byte normaliser; uses pbbn_decode and pbbn_pkg.
// An accepted word passes through the input register and then the result register before reaching m_*.
// Throughput: one word per cycle while the sink keeps m_tready high; the input register and
// the result register both advance in the same cycle, and the three state flags update once per word.
// Words that produce no result (escape, mode switch, dropped LF) leave no gap.
// Reset (rst_n low, asynchronous) empties both registers and clears all flags.
module printer_backchannel_byte_normalizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser    // [0] end_of_job_mark
);

    // Input register: holds one received word until the decoder can use it.
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;

    // Result register: holds one normalised word until the sink takes it.
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_eoj_reg;

    // Flags that carry from one word to the next.
    pbbn_pkg::pbbn_state_t  state_reg;
    pbbn_pkg::pbbn_state_t  state_next;
    pbbn_pkg::pbbn_result_t dec_result;

    logic                   out_free;
    logic                   advance;
    logic                   in_take;

    // The result register is free when empty or being emptied this cycle.
    assign out_free = !out_valid_reg || m_tready;
    // The word in the input register is decoded and retired this cycle.
    assign advance  = in_valid_reg && out_free;
    // The input register accepts a new word when empty or being retired.
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    pbbn_decode u_decode
    (
        .rx_byte   (in_byte_reg),
        .cur_state (state_reg),
        .nxt_state (state_next),
        .result    (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= dec_result.emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && dec_result.emit)
        begin
            out_byte_reg <= dec_result.data;
            out_eoj_reg  <= dec_result.eoj;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tuser[0] = out_eoj_reg;

    // An end-of-job marker always carries a zero data byte.
    a_eoj_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'h00))
        else $error("end-of-job marker with non-zero data");

    // Once TBCP mode is on it stays on until reset.
    a_tbcp_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.tbcp |=> state_reg.tbcp)
        else $error("TBCP mode dropped without reset");

    // An unescaped Control-A arms the escape for the following word.
    a_escape_arm: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !state_reg.esc && (in_byte_reg == pbbn_pkg::CH_CTRL_A))
            |=> (state_reg.esc && !m_tvalid) || (state_reg.esc && $stable(m_tdata)))
        else $error("Control-A did not arm the escape");

    // An empty input register always takes a word.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

endmodule

// ----- design/pbbn_decode.sv -----
// Combinational decoder for one back-channel byte.
// Maps a byte and the current flags to an optional output word and the
// next flags. Depends on pbbn_pkg.
module pbbn_decode
(
    input  logic [7:0]           rx_byte,
    input  pbbn_pkg::pbbn_state_t cur_state,
    output pbbn_pkg::pbbn_state_t nxt_state,
    output pbbn_pkg::pbbn_result_t result
);

    logic [7:0] esc_byte;

    // In TBCP mode an escaped byte has bit 6 flipped.
    assign esc_byte = cur_state.tbcp ? (rx_byte ^ pbbn_pkg::TBCP_XOR) : rx_byte;

    always_comb
    begin
        nxt_state = cur_state;
        result    = '0;
        if (cur_state.esc)
        begin
            nxt_state.esc = 1'b0;
            if (!cur_state.tbcp && (rx_byte == pbbn_pkg::CH_M))
            begin
                nxt_state.tbcp    = 1'b1;
                nxt_state.prev_cr = 1'b0;
            end
            else if (cur_state.tbcp && (esc_byte == pbbn_pkg::CH_CR))
            begin
                // An escaped CR is swallowed but still pairs with a following LF.
                nxt_state.prev_cr = 1'b1;
            end
            else
            begin
                nxt_state.prev_cr = (esc_byte == pbbn_pkg::CH_CR);
                result.emit       = 1'b1;
                result.data       = esc_byte;
            end
        end
        else
        begin
            unique case (rx_byte)
                pbbn_pkg::CH_CR:
                begin
                    nxt_state.prev_cr = 1'b1;
                    result.emit       = 1'b1;
                    result.data       = pbbn_pkg::CH_LF;
                end
                pbbn_pkg::CH_LF:
                begin
                    if (cur_state.prev_cr)
                    begin
                        nxt_state.prev_cr = 1'b0;
                    end
                    else
                    begin
                        result.emit = 1'b1;
                        result.data = pbbn_pkg::CH_LF;
                    end
                end
                pbbn_pkg::CH_CTRL_D:
                begin
                    nxt_state.prev_cr = 1'b0;
                    result.emit       = 1'b1;
                    result.eoj        = 1'b1;
                end
                pbbn_pkg::CH_NUL:
                begin
                    nxt_state.prev_cr = 1'b0;
                    result.emit       = 1'b1;
                    result.data       = pbbn_pkg::CH_QMARK;
                end
                pbbn_pkg::CH_CTRL_A:
                begin
                    nxt_state.esc = 1'b1;
                end
                default:
                begin
                    nxt_state.prev_cr = 1'b0;
                    result.emit       = 1'b1;
                    result.data       = rx_byte;
                end
            endcase
        end
    end

endmodule
